/* rtl/dap_pkg.sv */
`timescale 1ns / 1ps

package dap_pkg;

    localparam int DEF_MAX_LENGTH = 32;
    localparam int FRAC_DIGITS    = 10;

    localparam int WHOLE_W  = 40;
    localparam int FRAC_W   = 34;
    localparam int FCNT_W   = 4;
    localparam int HALF_W   = 20;
    localparam int PP_W     = HALF_W + FRAC_W;
    localparam int AMOUNT_W = 64;
    localparam int TOTAL_W  = PP_W + HALF_W + 1;

    localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 40'd1000000000000;
    localparam logic [FRAC_W-1:0]  SCALE       = 34'd10000000000;

    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic               ok;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [FCNT_W-1:0]  fcnt;
    } t_snap;

    // padding factor for a fraction with fewer than the full digit count
    function automatic logic [FRAC_W-1:0] pad_pow10(input logic [FCNT_W-1:0] n);
        logic [FRAC_W-1:0] p;
        begin
            case (n)
                4'd0:    p = 34'd1;
                4'd1:    p = 34'd10;
                4'd2:    p = 34'd100;
                4'd3:    p = 34'd1000;
                4'd4:    p = 34'd10000;
                4'd5:    p = 34'd100000;
                4'd6:    p = 34'd1000000;
                4'd7:    p = 34'd10000000;
                4'd8:    p = 34'd100000000;
                4'd9:    p = 34'd1000000000;
                4'd10:   p = 34'd10000000000;
                default: p = 34'd0;
            endcase
            return p;
        end
    endfunction

endpackage

/* rtl/dap_accum.sv */
`timescale 1ns / 1ps

module dap_accum
    import dap_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_end_of_text,
    input  logic [7:0]  i_character,
    output logic        o_snap_valid,
    input  logic        i_snap_ready,
    output t_snap       o_snap
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LENGTH);
    localparam logic [FCNT_W-1:0] FCNT_FULL = FCNT_W'(FRAC_DIGITS);
    localparam logic [FCNT_W-1:0] FCNT_SAT  = FCNT_W'(FRAC_DIGITS + 1);

    logic               r_in_valid;
    logic               r_in_eot;
    logic [7:0]         r_in_char;

    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_dot,   n_dot;
    logic               r_wnz,   n_wnz;
    logic [FCNT_W-1:0]  r_fcnt,  n_fcnt;
    logic [WHOLE_W-1:0] r_whole, n_whole;
    logic [FRAC_W-1:0]  r_frac,  n_frac;
    logic               r_bad,   n_bad;

    logic               proc;
    logic               is_digit;
    logic [3:0]         digit;
    logic [WHOLE_W+3:0] whole_x10;
    logic [FRAC_W+3:0]  frac_x10;

    assign proc       = r_in_valid && (!r_in_eot || i_snap_ready);
    assign o_in_ready = !r_in_valid || proc;

    assign is_digit  = (r_in_char >= CHAR_ZERO) && (r_in_char <= CHAR_NINE);
    assign digit     = r_in_char[3:0];
    assign whole_x10 = ({4'b0, r_whole} << 3) + ({4'b0, r_whole} << 1)
                       + {{WHOLE_W{1'b0}}, digit};
    assign frac_x10  = ({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1)
                       + {{FRAC_W{1'b0}}, digit};

    assign o_snap_valid = r_in_valid && r_in_eot;

    always_comb begin
        o_snap.ok    = !r_bad && (r_cnt != '0) && (r_cnt <= CNT_MAX)
                       && (r_wnz || (r_fcnt != '0)) && (r_fcnt <= FCNT_FULL)
                       && (r_whole <= WHOLE_LIMIT);
        o_snap.whole = r_whole;
        o_snap.frac  = r_frac;
        o_snap.fcnt  = r_fcnt;
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_dot   = r_dot;
        n_wnz   = r_wnz;
        n_fcnt  = r_fcnt;
        n_whole = r_whole;
        n_frac  = r_frac;
        n_bad   = r_bad;
        if (proc && r_in_eot) begin
            n_cnt   = '0;
            n_dot   = 1'b0;
            n_wnz   = 1'b0;
            n_fcnt  = '0;
            n_whole = '0;
            n_frac  = '0;
            n_bad   = 1'b0;
        end else if (proc) begin
            if (r_cnt < CNT_SAT) begin
                n_cnt = r_cnt + 1'b1;
            end
            if ((r_in_char == CHAR_DOT) && !r_dot) begin
                n_dot = 1'b1;
            end else if (!is_digit) begin
                n_bad = 1'b1;
            end else if (!r_dot) begin
                n_wnz = 1'b1;
                if (r_whole <= WHOLE_LIMIT) begin
                    if (whole_x10 > {4'b0, WHOLE_LIMIT}) begin
                        // saturate just above the limit
                        n_whole = WHOLE_LIMIT + 1'b1;
                        n_bad   = 1'b1;
                    end else begin
                        n_whole = whole_x10[WHOLE_W-1:0];
                    end
                end
            end else begin
                if (r_fcnt < FCNT_FULL) begin
                    n_frac = frac_x10[FRAC_W-1:0];
                    n_fcnt = r_fcnt + 1'b1;
                end else begin
                    n_fcnt = FCNT_SAT;
                    n_bad  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_dot      <= 1'b0;
            r_wnz      <= 1'b0;
            r_fcnt     <= '0;
            r_whole    <= '0;
            r_frac     <= '0;
            r_bad      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_cnt   <= n_cnt;
            r_dot   <= n_dot;
            r_wnz   <= n_wnz;
            r_fcnt  <= n_fcnt;
            r_whole <= n_whole;
            r_frac  <= n_frac;
            r_bad   <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_eot  <= i_end_of_text;
            r_in_char <= i_character;
        end
    end

endmodule

/* rtl/dap_scale.sv */
`timescale 1ns / 1ps

module dap_scale
    import dap_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_snap_valid,
    output logic                o_snap_ready,
    input  t_snap               i_snap,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [AMOUNT_W-1:0] o_amount,
    output logic                o_valid_res
);

    localparam logic [FCNT_W-1:0] FCNT_FULL = FCNT_W'(FRAC_DIGITS);

    logic                r_a_valid;
    logic                r_a_ok;
    logic [PP_W-1:0]     r_a_pp_lo;
    logic [PP_W-1:0]     r_a_pp_hi;
    logic [FRAC_W-1:0]   r_a_frac;

    logic                r_b_valid;
    logic                r_b_ok;
    logic [PP_W:0]       r_b_sum;
    logic [PP_W-1:0]     r_b_pp_hi;

    logic                r_o_valid;
    logic [AMOUNT_W-1:0] r_o_amount;
    logic                r_o_valid_res;

    logic                out_en;
    logic                b_en;
    logic                a_en;
    logic [FRAC_W-1:0]   pad;
    logic [2*FRAC_W-1:0] frac_prod;
    logic [TOTAL_W-1:0]  total;
    logic                res_ok;

    assign out_en       = !r_o_valid || i_out_ready;
    assign b_en         = !r_b_valid || out_en;
    assign a_en         = !r_a_valid || b_en;
    assign o_snap_ready = a_en;

    assign pad       = pad_pow10(FCNT_FULL - i_snap.fcnt);
    assign frac_prod = {{FRAC_W{1'b0}}, i_snap.frac} * {{FRAC_W{1'b0}}, pad};

    assign total  = {1'b0, r_b_pp_hi, {HALF_W{1'b0}}}
                    + {{HALF_W{1'b0}}, r_b_sum};
    assign res_ok = r_b_ok && (total[TOTAL_W-1:AMOUNT_W] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_valid <= i_snap_valid;
            end
            if (b_en) begin
                r_b_valid <= r_a_valid;
            end
            if (out_en) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    // whole part times scale in two halves, fraction padded on the right
    always_ff @(posedge i_clk) begin
        if (a_en && i_snap_valid) begin
            r_a_ok    <= i_snap.ok;
            r_a_pp_lo <= PP_W'({{FRAC_W{1'b0}}, i_snap.whole[HALF_W-1:0]}
                              * {{HALF_W{1'b0}}, SCALE});
            r_a_pp_hi <= PP_W'({{FRAC_W{1'b0}}, i_snap.whole[WHOLE_W-1:HALF_W]}
                              * {{HALF_W{1'b0}}, SCALE});
            r_a_frac  <= frac_prod[FRAC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en && r_a_valid) begin
            r_b_ok    <= r_a_ok;
            r_b_sum   <= {1'b0, r_a_pp_lo} + {{(PP_W - FRAC_W + 1){1'b0}}, r_a_frac};
            r_b_pp_hi <= r_a_pp_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_b_valid) begin
            r_o_valid_res <= res_ok;
            r_o_amount    <= res_ok ? total[AMOUNT_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_amount    = r_o_amount;
    assign o_valid_res = r_o_valid_res;

endmodule

/* rtl/decimal_amount_parser_unit.sv */
// throughput: one item per cycle for characters and end items while output is ready
// the result of an end item passes the input register, the multiply stage and the
// add stage, then it is held in the result register
// the running digit accumulation is a combinational update of the registered text state
// reset: synchronous active-low i_rst_n clears the text state and all valid flags
`timescale 1ns / 1ps

module decimal_amount_parser_unit
    import dap_pkg::*;
#(
    parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_end_of_text,
    input  logic [7:0]          i_character,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [AMOUNT_W-1:0] o_amount,
    output logic                o_valid_res
);

    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    dap_accum #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_end_of_text(i_end_of_text),
        .i_character  (i_character),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    dap_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_valid(snap_valid),
        .o_snap_ready(snap_ready),
        .i_snap      (snap),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_amount    (o_amount),
        .o_valid_res (o_valid_res)
    );

endmodule

/* tb/decimal_amount_parser_unit_test.sv */
`timescale 1ns / 1ps

module decimal_amount_parser_unit_test;
    import dap_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] FRAC_SCALE  = 64'd10000000000;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0] amount;
        logic        valid_res;
    } t_amount_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic                i_end_of_text = 1'b0;
    logic [7:0]          i_character   = 8'h00;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [AMOUNT_W-1:0] o_amount;
    logic                o_valid_res;

    // running parse of the current text
    logic [5:0]  txt_len;
    logic        txt_dot;
    logic        txt_has_whole;
    logic [3:0]  txt_frac_cnt;
    logic [63:0] txt_whole;
    logic [63:0] txt_frac;
    logic        txt_bad;

    t_amount_result pending_amounts[$];
    t_amount_result oldest_amount;
    logic [7:0]     text_buf[$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int items_sent    = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;

    decimal_amount_parser_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_end_of_text (i_end_of_text),
        .i_character   (i_character),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_amount      (o_amount),
        .o_valid_res   (o_valid_res)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void clear_text_state();
        txt_len       = '0;
        txt_dot       = 1'b0;
        txt_has_whole = 1'b0;
        txt_frac_cnt  = '0;
        txt_whole     = '0;
        txt_frac      = '0;
        txt_bad       = 1'b0;
    endfunction

    function automatic void parse_char(input logic [7:0] ch);
        logic        is_digit;
        logic [63:0] d;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        d = {56'd0, ch} - {56'd0, CHAR_ZERO};
        if (txt_len < DEF_MAX_LENGTH + 1)
            txt_len = txt_len + 1'b1;
        if (ch == CHAR_DOT && !txt_dot) begin
            txt_dot = 1'b1;
        end else if (!is_digit) begin
            txt_bad = 1'b1;
        end else if (!txt_dot) begin
            txt_has_whole = 1'b1;
            if (txt_whole <= WHOLE_LIMIT) begin
                txt_whole = txt_whole * 64'd10 + d;
                if (txt_whole > WHOLE_LIMIT)
                    txt_bad = 1'b1;
            end
        end else begin
            if (txt_frac_cnt < FRAC_DIGITS) begin
                txt_frac     = txt_frac * 64'd10 + d;
                txt_frac_cnt = txt_frac_cnt + 1'b1;
            end else begin
                txt_frac_cnt = 4'(FRAC_DIGITS + 1);
                txt_bad      = 1'b1;
            end
        end
    endfunction

    function automatic void close_text();
        t_amount_result res;
        logic [63:0]    padded;
        res.valid_res = !txt_bad;
        res.amount    = '0;
        if (txt_len == 0 || txt_len > DEF_MAX_LENGTH)
            res.valid_res = 1'b0;
        if (!txt_has_whole && txt_frac_cnt == 0)
            res.valid_res = 1'b0;
        if (txt_frac_cnt > FRAC_DIGITS)
            res.valid_res = 1'b0;
        if (txt_whole > WHOLE_LIMIT)
            res.valid_res = 1'b0;
        if (res.valid_res) begin
            padded = txt_frac;
            for (int i = txt_frac_cnt; i < FRAC_DIGITS; i++)
                padded = padded * 64'd10;
            if (txt_whole > (ALL_ONES - padded) / FRAC_SCALE)
                res.valid_res = 1'b0;
            else
                res.amount = txt_whole * FRAC_SCALE + padded;
        end
        pending_amounts.push_back(res);
        clear_text_state();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_amounts.size() == 0) begin
                report_mismatch("unexpected result", o_amount, 64'd0);
            end else begin
                oldest_amount = pending_amounts.pop_front();
                if (o_amount !== oldest_amount.amount)
                    report_mismatch("amount", o_amount, oldest_amount.amount);
                if (o_valid_res !== oldest_amount.valid_res)
                    report_mismatch("valid_res", {63'd0, o_valid_res},
                                    {63'd0, oldest_amount.valid_res});
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic eot, input logic [7:0] ch);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid    <= 1'b0;
            i_end_of_text <= 1'($urandom_range(0, 1));
            i_character   <= 8'($urandom_range(0, 255));
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_end_of_text <= eot;
        i_character   <= ch;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (eot)
            close_text();
        else
            parse_char(ch);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_item(1'b0, text_buf[i]);
        send_item(1'b1, 8'($urandom_range(0, 255)));
        text_buf.delete();
    endtask

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int n);
        for (int i = 0; i < n; i++)
            text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // short random amount, mostly few digits
    function automatic void add_plain_amount();
        int w;
        int f;
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 4);
        f = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3);
        if (w == 0 && f == 0)
            w = 1;
        add_digits(w);
        if (f > 0 || $urandom_range(0, 1))
            text_buf.push_back(CHAR_DOT);
        add_digits(f);
    endfunction

    task automatic test_edge_cases();
        send_text();
        add_str(".");
        send_text();
        add_str("5.");
        send_text();
        add_str(".5");
        send_text();
        add_str("1..");
        send_text();
        text_buf.push_back(8'h00);
        send_text();
        add_str(":");
        send_text();
        add_str("/");
        send_text();
        text_buf.push_back(8'hFF);
        send_text();
    endtask

    task automatic test_valid_amounts(input int n_items);
        int stop_at;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0: begin
                    case ($urandom_range(0, 9))
                        0: add_str("1844674407.3709551615");
                        1: add_str("1844674407.3709551616");
                        2: add_str("1844674407.370955161");
                        3: add_str("1844674408");
                        4: add_str("1000000000000");
                        5: add_str("1000000000001");
                        6: add_str("0.0000000001");
                        7: add_str("0");
                        8: add_str("99999999999999999");
                        default: add_str("0.00000000000");
                    endcase
                end
                1: begin
                    // leading zeros around the length limit
                    len = $urandom_range(30, 34);
                    for (int i = 0; i < len - 4; i++)
                        text_buf.push_back(CHAR_ZERO);
                    add_digits(2);
                    text_buf.push_back(CHAR_DOT);
                    add_digits(1);
                end
                2: begin
                    add_digits($urandom_range(0, 3));
                    text_buf.push_back(CHAR_DOT);
                    add_digits($urandom_range(9, 13));
                end
                3: begin
                    text_buf.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
                    add_digits($urandom_range(9, 14));
                    if ($urandom_range(0, 1)) begin
                        text_buf.push_back(CHAR_DOT);
                        add_digits($urandom_range(0, 10));
                    end
                end
                default: add_plain_amount();
            endcase
            send_text();
        end
    endtask

    task automatic test_malformed_text(input int n_items);
        int stop_at;
        int len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 4))
                0, 1, 2: begin
                    add_plain_amount();
                    text_buf.insert($urandom_range(0, text_buf.size()),
                                    8'($urandom_range(0, 255)));
                end
                3: begin
                    len = $urandom_range(0, 40);
                    for (int i = 0; i < len; i++)
                        text_buf.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    len = $urandom_range(0, 36);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 5) == 0)
                            text_buf.push_back(CHAR_DOT);
                        else
                            add_digits(1);
                    end
                end
            endcase
            send_text();
        end
    endtask

    initial begin
        clear_text_state();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_edge_cases();
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 25; sink_stall_pct = 25; end
            endcase
            test_valid_amounts(315);
            test_malformed_text(135);
        end

        i_in_valid <= 1'b0;
        while (pending_amounts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
